// ----- rtl/vog_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vog_pkg
// Shared types, codes and constants of the voxel occupancy grid.
// ----------------------------------------------------------------------------
package vog_pkg;

    localparam int unsigned MAX_X_DEF  = 64;
    localparam int unsigned MAX_Y_DEF  = 64;
    localparam int unsigned MAX_Z_DEF  = 64;

    localparam int unsigned COORD_W    = 16;
    localparam int unsigned CELL_W     = 6;
    localparam int unsigned EXT_W      = 7;
    localparam int unsigned CPM_W      = 16;
    localparam int unsigned PROD_W     = 32;
    localparam int unsigned CMD_W      = 2;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned MASK_W     = 6;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IN_DATA_W  = 72;
    localparam int unsigned OUT_DATA_W = 32;

    localparam logic [CPM_W-1:0] CPM_RST    = 16'd2560;
    localparam logic [EXT_W-1:0] EXTENT_RST = 7'd64;

    // face mask bit positions
    localparam int unsigned MB_XP = 0;
    localparam int unsigned MB_XN = 1;
    localparam int unsigned MB_YP = 2;
    localparam int unsigned MB_YN = 3;
    localparam int unsigned MB_ZP = 4;
    localparam int unsigned MB_ZN = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_MARK  = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_SURF  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_FREE = 2'd0,
        STS_OCC  = 2'd1,
        STS_OOM  = 2'd2,
        STS_DONE = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_CPM      = 3'd3,
        CFG_EXTENT_X = 3'd4,
        CFG_EXTENT_Y = 3'd5,
        CFG_EXTENT_Z = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    typedef enum logic [2:0] {
        PRB_CENTER = 3'd0,
        PRB_XP     = 3'd1,
        PRB_XN     = 3'd2,
        PRB_YP     = 3'd3,
        PRB_YN     = 3'd4,
        PRB_END    = 3'd5
    } t_probe;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCALE,
        S_DRAIN,
        S_DECIDE,
        S_APPLY,
        S_CHECK,
        S_PROBE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              valid;
        t_axis             axis;
        logic              neg;
        logic [PROD_W-1:0] prod;
    } t_scale_res;

    // zero acts as one, anything above the grid size acts as the grid size
    function automatic logic [EXT_W-1:0] eff_extent(input logic [EXT_W-1:0] e,
                                                    input int unsigned maxv);
        logic [EXT_W-1:0] r;
        if (e == '0) begin
            r = 7'd1;
        end else if (32'(e) > maxv) begin
            r = EXT_W'(maxv);
        end else begin
            r = e;
        end
        return r;
    endfunction

endpackage

// ----- rtl/voxel_occupancy_grid.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_occupancy_grid
// 3D occupancy bit grid with mark, query and surface test commands.
// ----------------------------------------------------------------------------
// Input words arrive on the s_axis channel (command in tuser), results leave
// on the m_axis channel, one result word per input word, in order. Registers
// are written over the cfg channel, which is always ready; write it only
// while no word is in flight.
// The grid lives in one single-port memory holding one z column per word,
// so a cell and its two z neighbours come in one read.
// Per word, from the accept up to the load of the result register: mark
// and query take three axis scale steps through one shared multiplier, a
// drain, a read, then the write back or bit test, and skip the read when
// the point lies outside; surface test makes five column reads through the
// single memory port, only the first when the cell lies outside; an unknown
// command goes straight to the result. The next word is taken the cycle
// after the load, so the block works on one word at a time. A new word is
// accepted while the previous result still waits in the output register,
// but a finished word waits for the register to drain when the receiver
// stalls. After reset the block sweeps the memory clear, one column per
// cycle, all 2**(clog2(MAX_X) + clog2(MAX_Y)) columns (4096 by default),
// before s_axis_tready rises.
// ----------------------------------------------------------------------------
module voxel_occupancy_grid #(
    parameter int unsigned MAX_X = vog_pkg::MAX_X_DEF,
    parameter int unsigned MAX_Y = vog_pkg::MAX_Y_DEF,
    parameter int unsigned MAX_Z = vog_pkg::MAX_Z_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [vog_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [vog_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // coord_x, coord_y, coord_z, cell_x, cell_y, cell_z, zero fill
    input  logic [vog_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // cmd
    input  logic [vog_pkg::CMD_W-1:0]         i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // status, face_mask, index_x, index_y, index_z, zero fill
    output logic [vog_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata
);
    import vog_pkg::*;

    localparam int unsigned XW = $clog2(MAX_X);
    localparam int unsigned YW = $clog2(MAX_Y);
    localparam int unsigned ZW = $clog2(MAX_Z);
    localparam int unsigned AW = XW + YW;

    localparam logic [EXT_W-1:0] EXT_RST_X = eff_extent(EXTENT_RST, MAX_X);
    localparam logic [EXT_W-1:0] EXT_RST_Y = eff_extent(EXTENT_RST, MAX_Y);
    localparam logic [EXT_W-1:0] EXT_RST_Z = eff_extent(EXTENT_RST, MAX_Z);

    // configuration
    logic signed [COORD_W-1:0] r_org_x, r_org_y, r_org_z;
    logic [CPM_W-1:0]          r_cpm;
    logic [EXT_W-1:0]          r_ext_x, r_ext_y, r_ext_z;

    // control
    t_state          r_state, n_state;
    t_axis           r_axis;
    t_probe          r_step, r_tag;
    logic [AW-1:0]   r_clr_addr;
    logic            r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    // item
    t_cmd                      r_cmd;
    logic signed [COORD_W-1:0] r_coord_x, r_coord_y, r_coord_z;
    logic [CELL_W-1:0]         r_cell_x, r_cell_y, r_cell_z;
    logic [XW-1:0]             r_idx_x;
    logic [YW-1:0]             r_idx_y;
    logic [ZW-1:0]             r_idx_z;
    logic                      r_bad;
    t_status                   r_res_status;
    logic [MASK_W-1:0]         r_mask;
    logic [CELL_W-1:0]         r_res_ix, r_res_iy, r_res_iz;

    logic s_acc, out_load, s_ready;

    // scale unit
    logic                      scale_en;
    logic signed [COORD_W-1:0] scale_coord, scale_origin;
    t_scale_res                scale_res;

    // resolve
    logic [EXT_W-1:0]   ext_sel;
    logic [COORD_W-1:0] ext16, pint;
    logic               in_ok, oom, axis_bad;
    logic [EXT_W-1:0]   clamp;

    // memory
    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_addr;
    logic [MAX_Z-1:0] mem_wdata, mem_rdata;

    // neighbours
    logic [XW-1:0] x_p1, x_m1;
    logic [YW-1:0] y_p1, y_m1;
    logic [ZW-1:0] z_p1, z_m1;
    logic          xp_ok, xn_ok, yp_ok, yn_ok, zp_ok, zn_ok, surf_bad;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = s_ready;
    assign s_acc           = i_s_axis_tvalid && s_ready;
    assign out_load        = (r_state == S_DONE) && (!r_out_valid || i_m_axis_tready);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_org_z <= '0;
            r_cpm   <= CPM_RST;
            r_ext_x <= EXT_RST_X;
            r_ext_y <= EXT_RST_Y;
            r_ext_z <= EXT_RST_Z;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ORIGIN_X: r_org_x <= i_cfg_data;
                CFG_ORIGIN_Y: r_org_y <= i_cfg_data;
                CFG_ORIGIN_Z: r_org_z <= i_cfg_data;
                CFG_CPM:      r_cpm   <= i_cfg_data;
                CFG_EXTENT_X: r_ext_x <= eff_extent(i_cfg_data[EXT_W-1:0], MAX_X);
                CFG_EXTENT_Y: r_ext_y <= eff_extent(i_cfg_data[EXT_W-1:0], MAX_Y);
                CFG_EXTENT_Z: r_ext_z <= eff_extent(i_cfg_data[EXT_W-1:0], MAX_Z);
                default: ;
            endcase
        end
    end

    // scale one axis per cycle
    always_comb begin
        case (r_axis)
            AXIS_Y: begin
                scale_coord  = r_coord_y;
                scale_origin = r_org_y;
            end
            AXIS_Z: begin
                scale_coord  = r_coord_z;
                scale_origin = r_org_z;
            end
            default: begin
                scale_coord  = r_coord_x;
                scale_origin = r_org_x;
            end
        endcase
    end

    vog_scale_unit u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (scale_en),
        .i_axis   (r_axis),
        .i_coord  (scale_coord),
        .i_origin (scale_origin),
        .i_cpm    (r_cpm),
        .o_res    (scale_res)
    );

    // index and range check of the axis that just left the scale unit
    always_comb begin
        case (scale_res.axis)
            AXIS_Y:  ext_sel = r_ext_y;
            AXIS_Z:  ext_sel = r_ext_z;
            default: ext_sel = r_ext_x;
        endcase
        ext16  = COORD_W'(ext_sel);
        pint   = scale_res.prod[PROD_W-1:COORD_W];
        in_ok  = !scale_res.neg && (pint < ext16);
        oom    = scale_res.neg || (pint > ext16)
              || ((pint == ext16) && (scale_res.prod[COORD_W-1:0] != '0));
        clamp  = (pint >= ext16) ? ext_sel - 7'd1 : pint[EXT_W-1:0];
        axis_bad = (r_cmd == CMD_MARK) ? !in_ok : oom;
    end

    // neighbour addresses and in-grid tests
    assign x_p1  = r_idx_x + 1'b1;
    assign x_m1  = r_idx_x - 1'b1;
    assign y_p1  = r_idx_y + 1'b1;
    assign y_m1  = r_idx_y - 1'b1;
    assign z_p1  = r_idx_z + 1'b1;
    assign z_m1  = r_idx_z - 1'b1;
    assign xp_ok = ({1'b0, r_cell_x} + 7'd1) < r_ext_x;
    assign yp_ok = ({1'b0, r_cell_y} + 7'd1) < r_ext_y;
    assign zp_ok = ({1'b0, r_cell_z} + 7'd1) < r_ext_z;
    assign xn_ok = (r_cell_x != '0);
    assign yn_ok = (r_cell_y != '0);
    assign zn_ok = (r_cell_z != '0);
    assign surf_bad = ({1'b0, r_cell_x} >= r_ext_x) || ({1'b0, r_cell_y} >= r_ext_y)
                   || ({1'b0, r_cell_z} >= r_ext_z);

    vog_grid_ram #(
        .AW (AW),
        .DW (MAX_Z)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        s_ready   = 1'b0;
        scale_en  = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = {r_idx_x, r_idx_y};
        mem_wdata = mem_rdata | (MAX_Z'(1) << r_idx_z);
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr_addr;
                mem_wdata = '0;
                if (&r_clr_addr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_acc) begin
                    case (t_cmd'(i_s_axis_tuser)) inside
                        CMD_MARK, CMD_QUERY: n_state = S_SCALE;
                        CMD_SURF:            n_state = S_CHECK;
                        default:             n_state = S_DONE;
                    endcase
                end
            end
            S_SCALE: begin
                scale_en = 1'b1;
                if (r_axis == AXIS_Z) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (r_bad) begin
                    n_state = S_DONE;
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                mem_we  = (r_cmd == CMD_MARK);
                n_state = S_DONE;
            end
            S_CHECK: begin
                mem_re  = 1'b1;
                n_state = surf_bad ? S_DONE : S_PROBE;
            end
            S_PROBE: begin
                mem_re = (r_step != PRB_END);
                case (r_step)
                    PRB_XP:  mem_addr = {x_p1, r_idx_y};
                    PRB_XN:  mem_addr = {x_m1, r_idx_y};
                    PRB_YP:  mem_addr = {r_idx_x, y_p1};
                    PRB_YN:  mem_addr = {r_idx_x, y_m1};
                    default: mem_addr = {r_idx_x, r_idx_y};
                endcase
                if (r_step == PRB_END) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control counters and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_axis      <= AXIS_X;
            r_step      <= PRB_XP;
            r_tag       <= PRB_CENTER;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == S_IDLE) begin
                r_axis <= AXIS_X;
            end else if (r_state == S_SCALE) begin
                r_axis <= t_axis'(r_axis + 2'd1);
            end
            if (r_state == S_CHECK) begin
                r_tag  <= PRB_CENTER;
                r_step <= PRB_XP;
            end else if (r_state == S_PROBE && r_step != PRB_END) begin
                r_tag  <= r_step;
                r_step <= t_probe'(r_step + 3'd1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        if (scale_res.valid) begin
            r_bad <= r_bad | axis_bad;
            case (scale_res.axis)
                AXIS_Y:  r_idx_y <= YW'(clamp);
                AXIS_Z:  r_idx_z <= ZW'(clamp);
                default: r_idx_x <= XW'(clamp);
            endcase
        end
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    r_cmd        <= t_cmd'(i_s_axis_tuser);
                    r_coord_x    <= i_s_axis_tdata[15:0];
                    r_coord_y    <= i_s_axis_tdata[31:16];
                    r_coord_z    <= i_s_axis_tdata[47:32];
                    r_cell_x     <= i_s_axis_tdata[53:48];
                    r_cell_y     <= i_s_axis_tdata[59:54];
                    r_cell_z     <= i_s_axis_tdata[65:60];
                    r_idx_x      <= XW'(i_s_axis_tdata[53:48]);
                    r_idx_y      <= YW'(i_s_axis_tdata[59:54]);
                    r_idx_z      <= ZW'(i_s_axis_tdata[65:60]);
                    r_bad        <= 1'b0;
                    r_mask       <= '0;
                    r_res_status <= STS_DONE;
                    r_res_ix     <= '0;
                    r_res_iy     <= '0;
                    r_res_iz     <= '0;
                end
            end
            S_DECIDE: begin
                if (r_bad) begin
                    r_res_status <= (r_cmd == CMD_MARK) ? STS_DONE : STS_OOM;
                end
            end
            S_APPLY: begin
                r_res_ix <= CELL_W'(r_idx_x);
                r_res_iy <= CELL_W'(r_idx_y);
                r_res_iz <= CELL_W'(r_idx_z);
                if (r_cmd == CMD_MARK) begin
                    r_res_status <= STS_DONE;
                end else begin
                    r_res_status <= mem_rdata[r_idx_z] ? STS_OCC : STS_FREE;
                end
            end
            S_CHECK: begin
                r_res_status <= STS_OOM;
                r_res_ix     <= r_cell_x;
                r_res_iy     <= r_cell_y;
                r_res_iz     <= r_cell_z;
            end
            S_PROBE: begin
                case (r_tag)
                    PRB_CENTER: begin
                        r_res_status  <= mem_rdata[r_idx_z] ? STS_OCC : STS_FREE;
                        r_mask[MB_ZP] <= zp_ok && !mem_rdata[z_p1];
                        r_mask[MB_ZN] <= zn_ok && !mem_rdata[z_m1];
                    end
                    PRB_XP: r_mask[MB_XP] <= xp_ok && !mem_rdata[r_idx_z];
                    PRB_XN: r_mask[MB_XN] <= xn_ok && !mem_rdata[r_idx_z];
                    PRB_YP: r_mask[MB_YP] <= yp_ok && !mem_rdata[r_idx_z];
                    PRB_YN: r_mask[MB_YN] <= yn_ok && !mem_rdata[r_idx_z];
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (out_load) begin
            r_out_data <= {6'd0, r_res_iz, r_res_iy, r_res_ix, r_mask, r_res_status};
        end
    end

endmodule

// ----- rtl/vog_scale_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vog_scale_unit
// Shared offset and scale stage: one axis per cycle, registered result.
// ----------------------------------------------------------------------------
module vog_scale_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  vog_pkg::t_axis                      i_axis,
    input  logic signed [vog_pkg::COORD_W-1:0]  i_coord,
    input  logic signed [vog_pkg::COORD_W-1:0]  i_origin,
    input  logic        [vog_pkg::CPM_W-1:0]    i_cpm,
    output vog_pkg::t_scale_res                 o_res
);
    import vog_pkg::*;

    logic signed [COORD_W:0] diff;
    logic [PROD_W-1:0]       prod;
    logic                    r_valid;
    t_axis                   r_axis;
    logic                    r_neg;
    logic [PROD_W-1:0]       r_prod;

    assign diff = {i_coord[COORD_W-1], i_coord} - {i_origin[COORD_W-1], i_origin};
    // offset is known non-negative whenever the product is used
    assign prod = PROD_W'(diff[COORD_W-1:0]) * PROD_W'(i_cpm);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_axis <= i_axis;
            r_neg  <= diff[COORD_W];
            r_prod <= prod;
        end
    end

    assign o_res = '{valid: r_valid, axis: r_axis, neg: r_neg, prod: r_prod};

endmodule

// ----- rtl/vog_grid_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vog_grid_ram
// Single-port grid memory, one z column per word, registered read.
// ----------------------------------------------------------------------------
module vog_grid_ram #(
    parameter int unsigned AW = 12,
    parameter int unsigned DW = 64
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic          i_re,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- bench/grid_answer_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_answer_checker
// Watches the register, input and result channels of the voxel occupancy
// grid, keeps its own occupancy grid and register copy, works out the answer
// to every accepted word and compares each result word field by field with
// the oldest outstanding answer.
// ----------------------------------------------------------------------------
module grid_answer_checker
    import vog_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_axis_tvalid,
    input  logic                  i_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input  logic [CMD_W-1:0]      i_s_axis_tuser,
    input  logic                  i_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    input  logic [OUT_DATA_W-1:0] i_m_axis_tdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int unsigned CELLS     = MAX_X_DEF * MAX_Y_DEF * MAX_Z_DEF;
    localparam int unsigned CELL_BASE = 3 * COORD_W;
    localparam int unsigned ANSWER_W  = STATUS_W + MASK_W + 3 * CELL_W;

    // packed from the top bit down, so status lands in the lowest bits
    typedef struct packed {
        logic [CELL_W-1:0] idx_z;
        logic [CELL_W-1:0] idx_y;
        logic [CELL_W-1:0] idx_x;
        logic [MASK_W-1:0] face_mask;
        t_status           status;
    } t_answer;

    bit                        occ [0:CELLS-1];
    logic signed [COORD_W-1:0] org [3];
    logic [CPM_W-1:0]          cpm;
    logic [EXT_W-1:0]          ext [3];
    t_answer                   pending_answers [$];
    int                        fails = 0;

    // extent in use: zero acts as one, above the grid size acts as the grid size
    function automatic int unsigned eff_span(input int axis);
        int unsigned limit;
        int unsigned e;
        case (axis)
            0:       limit = MAX_X_DEF;
            1:       limit = MAX_Y_DEF;
            default: limit = MAX_Z_DEF;
        endcase
        e = ext[axis];
        if (e == 0) begin
            e = 1;
        end else if (e > limit) begin
            e = limit;
        end
        return e;
    endfunction

    function automatic int unsigned cell_addr(input int x, input int y, input int z);
        return x * MAX_Y_DEF * MAX_Z_DEF + y * MAX_Z_DEF + z;
    endfunction

    function automatic bit is_set(input int x, input int y, input int z);
        return occ[cell_addr(x, y, z)];
    endfunction

    // offset from the origin times cells per metre, Q16.16; 0 below the origin
    function automatic bit scale_axis(input logic signed [COORD_W-1:0] coord,
                                      input logic signed [COORD_W-1:0] origin,
                                      output longint prod);
        longint d;
        d = longint'(coord) - longint'(origin);
        prod = 0;
        if (d < 0) begin
            return 1'b0;
        end
        prod = d * longint'(cpm);
        return 1'b1;
    endfunction

    // answer to one word; a mark sets its cell in the local grid
    function automatic t_answer predict_answer(input t_cmd cmd,
                                               input logic [IN_DATA_W-1:0] data);
        t_answer                   a;
        int unsigned               span [3];
        logic signed [COORD_W-1:0] c [3];
        longint                    p [3];
        int                        k [3];
        bit                        ok;
        bit                        in_grid;
        bit                        oom;
        a = '0;
        a.status = STS_DONE;
        for (int i = 0; i < 3; i++) begin
            span[i] = eff_span(i);
            c[i] = data[i*COORD_W +: COORD_W];
            k[i] = int'(data[CELL_BASE + i*CELL_W +: CELL_W]);
        end
        case (cmd)
            CMD_MARK, CMD_QUERY: begin
                ok = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    if (!scale_axis(c[i], org[i], p[i])) ok = 1'b0;
                end
                if (cmd == CMD_MARK) begin
                    in_grid = ok;
                    for (int i = 0; i < 3; i++) begin
                        if ((p[i] >> 16) >= span[i]) in_grid = 1'b0;
                    end
                    if (in_grid) begin
                        for (int i = 0; i < 3; i++) k[i] = int'(p[i] >> 16);
                        occ[cell_addr(k[0], k[1], k[2])] = 1'b1;
                        a.idx_x = CELL_W'(k[0]);
                        a.idx_y = CELL_W'(k[1]);
                        a.idx_z = CELL_W'(k[2]);
                    end
                end else begin
                    oom = !ok;
                    for (int i = 0; i < 3; i++) begin
                        if (p[i] > (longint'(span[i]) << 16)) oom = 1'b1;
                    end
                    if (oom) begin
                        a.status = STS_OOM;
                    end else begin
                        // a point on the upper face clamps to the last cell
                        for (int i = 0; i < 3; i++) begin
                            k[i] = int'(p[i] >> 16);
                            if (k[i] > span[i] - 1) k[i] = int'(span[i] - 1);
                        end
                        a.status = is_set(k[0], k[1], k[2]) ? STS_OCC : STS_FREE;
                        a.idx_x = CELL_W'(k[0]);
                        a.idx_y = CELL_W'(k[1]);
                        a.idx_z = CELL_W'(k[2]);
                    end
                end
            end
            CMD_SURF: begin
                a.idx_x = CELL_W'(k[0]);
                a.idx_y = CELL_W'(k[1]);
                a.idx_z = CELL_W'(k[2]);
                if (k[0] >= span[0] || k[1] >= span[1] || k[2] >= span[2]) begin
                    a.status = STS_OOM;
                end else begin
                    a.status = is_set(k[0], k[1], k[2]) ? STS_OCC : STS_FREE;
                    if (k[0] + 1 < span[0] && !is_set(k[0] + 1, k[1], k[2]))
                        a.face_mask[MB_XP] = 1'b1;
                    if (k[0] > 0 && !is_set(k[0] - 1, k[1], k[2]))
                        a.face_mask[MB_XN] = 1'b1;
                    if (k[1] + 1 < span[1] && !is_set(k[0], k[1] + 1, k[2]))
                        a.face_mask[MB_YP] = 1'b1;
                    if (k[1] > 0 && !is_set(k[0], k[1] - 1, k[2]))
                        a.face_mask[MB_YN] = 1'b1;
                    if (k[2] + 1 < span[2] && !is_set(k[0], k[1], k[2] + 1))
                        a.face_mask[MB_ZP] = 1'b1;
                    if (k[2] > 0 && !is_set(k[0], k[1], k[2] - 1))
                        a.face_mask[MB_ZN] = 1'b1;
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_answer want;
        t_answer got;
        if (!i_rst_n) begin
            foreach (occ[i]) occ[i] = 1'b0;
            for (int i = 0; i < 3; i++) begin
                org[i] = '0;
                ext[i] = EXTENT_RST;
            end
            cpm = CPM_RST;
            pending_answers.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_ORIGIN_X: org[0] = i_cfg_data;
                    CFG_ORIGIN_Y: org[1] = i_cfg_data;
                    CFG_ORIGIN_Z: org[2] = i_cfg_data;
                    CFG_CPM:      cpm    = i_cfg_data;
                    CFG_EXTENT_X: ext[0] = i_cfg_data[EXT_W-1:0];
                    CFG_EXTENT_Y: ext[1] = i_cfg_data[EXT_W-1:0];
                    CFG_EXTENT_Z: ext[2] = i_cfg_data[EXT_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                pending_answers = {pending_answers,
                                   predict_answer(t_cmd'(i_s_axis_tuser), i_s_axis_tdata)};
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = i_m_axis_tdata[ANSWER_W-1:0];
                if (pending_answers.size() == 0) begin
                    fails++;
                    $display("%0t: result word with no answer outstanding, expected none, got %h",
                             $time, i_m_axis_tdata);
                end else begin
                    want = pending_answers.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("face_mask", want.face_mask, got.face_mask);
                    check_field("index_x", want.idx_x, got.idx_x);
                    check_field("index_y", want.idx_y, got.idx_y);
                    check_field("index_z", want.idx_z, got.idx_z);
                    check_field("zero fill", 0, i_m_axis_tdata[OUT_DATA_W-1:ANSWER_W]);
                end
            end
        end
        o_pending    <= pending_answers.size();
        o_fail_count <= fails;
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the voxel occupancy grid: a directed pass over
// the edges of the index conversion, upper-edge clamping, zero scale and
// extent limits, then random phases under several register settings with
// bursty input, a stalling receiver and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import vog_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int PHASES        = 8;
    localparam int IDLE_LIMIT    = 20000;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_AT       = 650;
    localparam int SETTLE_CYCLES = 16;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [IN_DATA_W-1:0]  in_data   = '0;
    logic [CMD_W-1:0]      in_cmd    = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [OUT_DATA_W-1:0] out_data;

    int fail_count;
    int pending_count;
    int sent_count  = 0;
    int burst_left  = 0;
    int idle_cycles = 0;

    // register copy, only used to aim the random points at the grid
    int cur_org [3];
    int cur_cpm;
    int cur_ext [3];

    always #(CLK_PERIOD / 2) clk = ~clk;

    voxel_occupancy_grid uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),
        .i_s_axis_tuser  (in_cmd),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data)
    );

    grid_answer_checker answer_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (in_valid),
        .i_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),
        .i_s_axis_tuser  (in_cmd),
        .i_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .i_m_axis_tdata  (out_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending_count)
    );

    // nothing accepted on any channel for too long ends the run
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("voxel_occupancy_grid test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: segments of steady, light and heavy stalling, one long hold
    initial begin : result_sink
        int  seg_left;
        int  mode;
        bit  held;
        seg_left = 0;
        mode     = 0;
        held     = 1'b0;
        forever begin
            @(posedge clk);
            if (!held && sent_count >= HOLD_AT) begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (seg_left == 0) begin
                mode     = $urandom_range(0, 3);
                seg_left = $urandom_range(20, 200);
            end
            seg_left--;
            case (mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 1) == 1);
                2:       out_ready <= ($urandom_range(0, 9) != 0);
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    function automatic int span_of(input int axis);
        int limit;
        int e;
        case (axis)
            0:       limit = MAX_X_DEF;
            1:       limit = MAX_Y_DEF;
            default: limit = MAX_Z_DEF;
        endcase
        e = cur_ext[axis];
        if (e == 0) e = 1;
        if (e > limit) e = limit;
        return e;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_item(
            input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
            input logic [COORD_W-1:0] cz, input logic [CELL_W-1:0] kx,
            input logic [CELL_W-1:0] ky, input logic [CELL_W-1:0] kz);
        return IN_DATA_W'({kz, ky, kx, cz, cy, cx});
    endfunction

    // mostly points inside or just past the grid, some around its faces, some noise
    function automatic logic [COORD_W-1:0] pick_coord(input int axis);
        int span;
        int reach;
        int d;
        int c;
        span = span_of(axis);
        if (cur_cpm == 0) begin
            reach = 64;
        end else begin
            reach = ((span + 1) * 65536) / cur_cpm + 2;
        end
        if (reach > 65535) reach = 65535;
        case ($urandom_range(0, 9))
            0: return COORD_W'($urandom);
            1: d = int'($urandom_range(0, 4)) - 2;
            2: begin
                if (cur_cpm == 0) begin
                    d = $urandom_range(0, 4);
                end else begin
                    d = (span * 65536) / cur_cpm + int'($urandom_range(0, 4)) - 2;
                end
            end
            default: d = $urandom_range(0, reach);
        endcase
        c = cur_org[axis] + d;
        if (c > 32767 || c < -32768) return COORD_W'($urandom);
        return COORD_W'(c);
    endfunction

    task automatic load_config(input int ox, input int oy, input int oz, input int cpm,
                               input int ex, input int ey, input int ez);
        t_cfg_idx idx;
        idx = idx.first();
        do begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            case (idx)
                CFG_ORIGIN_X: begin cfg_data <= CFG_DATA_W'(ox); cur_org[0] = ox; end
                CFG_ORIGIN_Y: begin cfg_data <= CFG_DATA_W'(oy); cur_org[1] = oy; end
                CFG_ORIGIN_Z: begin cfg_data <= CFG_DATA_W'(oz); cur_org[2] = oz; end
                CFG_CPM:      begin cfg_data <= CFG_DATA_W'(cpm); cur_cpm = cpm; end
                CFG_EXTENT_X: begin cfg_data <= CFG_DATA_W'(ex); cur_ext[0] = ex; end
                CFG_EXTENT_Y: begin cfg_data <= CFG_DATA_W'(ey); cur_ext[1] = ey; end
                default:      begin cfg_data <= CFG_DATA_W'(ez); cur_ext[2] = ez; end
            endcase
            do @(posedge clk); while (!cfg_ready);
            idx = idx.next();
        end while (idx != idx.first());
        cfg_valid <= 1'b0;
    endtask

    // one word; bursts of back-to-back words separated by random gaps
    task automatic send_item(input t_cmd cmd, input logic [IN_DATA_W-1:0] data);
        in_valid <= 1'b1;
        in_cmd   <= cmd;
        in_data  <= data;
        do @(posedge clk); while (!in_ready);
        sent_count++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 6);
        end
    endtask

    task automatic send_point(input t_cmd cmd, input int x, input int y, input int z);
        send_item(cmd, pack_item(COORD_W'(x), COORD_W'(y), COORD_W'(z), '0, '0, '0));
    endtask

    task automatic send_cell(input int x, input int y, input int z);
        send_item(CMD_SURF, pack_item('0, '0, '0, CELL_W'(x), CELL_W'(y), CELL_W'(z)));
    endtask

    task automatic send_random();
        int                r;
        t_cmd              cmd;
        logic [COORD_W-1:0] c [3];
        logic [CELL_W-1:0]  k [3];
        r = $urandom_range(0, 99);
        cmd = (r < 40) ? CMD_MARK : (r < 70) ? CMD_QUERY : (r < 95) ? CMD_SURF : CMD_NOP;
        for (int i = 0; i < 3; i++) begin
            c[i] = pick_coord(i);
            if ($urandom_range(0, 9) < 8) begin
                k[i] = CELL_W'($urandom_range(0, span_of(i) - 1));
            end else begin
                k[i] = CELL_W'($urandom);
            end
        end
        send_item(cmd, pack_item(c[0], c[1], c[2], k[0], k[1], k[2]));
    endtask

    // registers change only once every answer is back and the block is quiet
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        for (int i = 0; i < 3; i++) begin
            cur_org[i] = 0;
            cur_ext[i] = EXTENT_RST;
        end
        cur_cpm = CPM_RST;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: ten cells per metre, full 64 cube
        send_point(CMD_QUERY, 0, 0, 0);
        send_point(CMD_MARK, 0, 0, 0);
        send_point(CMD_QUERY, 0, 0, 0);
        send_point(CMD_MARK, 26, 52, 1637);
        send_point(CMD_QUERY, 26, 52, 1637);
        send_point(CMD_MARK, 32767, 0, 0);
        send_point(CMD_MARK, -32768, 0, 0);
        send_point(CMD_QUERY, -1, 0, 0);
        send_point(CMD_QUERY, 0, 0, 1639);
        send_cell(0, 0, 0);
        send_cell(1, 2, 62);
        send_cell(63, 63, 63);
        send_item(CMD_NOP, pack_item('1, '1, '1, '1, '1, '1));
        wait_drained();

        // one cell per metre: points on the upper face clamp to the last cell
        load_config(0, 0, 0, 256, 64, 64, 10);
        send_point(CMD_QUERY, 16384, 16384, 2560);
        send_point(CMD_MARK, 16384, 0, 0);
        send_point(CMD_QUERY, 16385, 0, 0);
        send_point(CMD_MARK, 16383, 16383, 2559);
        send_point(CMD_QUERY, 16384, 16384, 2560);
        send_cell(0, 0, 10);
        send_cell(63, 63, 9);
        wait_drained();

        // zero scale, extent zero and extent above the grid size
        load_config(-512, -512, -512, 0, 0, 100, 64);
        send_point(CMD_MARK, -512, 32767, 100);
        send_point(CMD_QUERY, -513, 0, 0);
        send_point(CMD_QUERY, 32767, 32767, 32767);
        send_cell(0, 5, 5);
        send_cell(1, 0, 0);
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: load_config(-256, 512, -1024, 4096, 6, 4, 8);
                1: load_config(32767, 32767, 32767, 65535, 64, 64, 64);
                2: load_config(-32768, -32768, -32768, 1, 1, 1, 1);
                3: load_config(0, 0, 0, 0, 0, 100, 3);
                4: load_config(0, 0, 0, CPM_RST, 64, 64, 64);
                default: begin
                    load_config(int'($urandom_range(0, 4000)) - 2000,
                                int'($urandom_range(0, 4000)) - 2000,
                                int'($urandom_range(0, 4000)) - 2000,
                                ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                                            : $urandom_range(512, 8192),
                                $urandom_range(0, 1) ? $urandom_range(1, 8)
                                                     : $urandom_range(1, 64),
                                $urandom_range(0, 1) ? $urandom_range(1, 8)
                                                     : $urandom_range(1, 64),
                                $urandom_range(0, 1) ? $urandom_range(1, 8)
                                                     : $urandom_range(1, 64));
                end
            endcase
            repeat (RANDOM_ITEMS / PHASES) send_random();
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("voxel_occupancy_grid test passed");
        end else begin
            $display("voxel_occupancy_grid test failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/vog_pkg.sv
rtl/vog_scale_unit.sv
rtl/vog_grid_ram.sv
rtl/voxel_occupancy_grid.sv
bench/grid_answer_checker.sv
bench/testbench.sv
